[design/cartesian_polar_converter_assert.svh]
// Assertion macros for the coordinate converter.
`ifndef CARTESIAN_POLAR_CONVERTER_ASSERT_SVH
`define CARTESIAN_POLAR_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, muted while reset is high.
`define CPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cartesian_polar_converter: implication failed");

// Next-cycle implication, also checked during reset.
`define CPC_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cartesian_polar_converter: next-cycle check failed");

`else

`define CPC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CPC_ASSERT_NEXT(label, clk, ante, cons)

`endif

`endif

[design/cpc_pkg.sv]
package cpc_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ATAN_LEN  = 24;
  localparam int VEC_W     = 32;
  localparam int GAIN_W    = 30;

  // atan(2^-i) with 2^31 = pi
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic               func;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic signed [15:0] angle_in;
    logic        [14:0] radius_in;
  } cpc_req_t;

  // One item on its way through the micro-rotation stages
  typedef struct packed {
    logic                    valid;
    logic                    func;
    logic                    zero;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic        [31:0]      z;
  } cpc_beat_t;

  typedef struct packed {
    logic               valid;
    logic               func;
    logic signed [15:0] phase_out;
    logic        [15:0] radius_out;
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
  } cpc_res_t;

  // Square of the CORDIC gain in Q60, for the given number of steps
  function automatic logic [63:0] gain_sq(input int n);
    logic [63:0] p;
    p = 64'd1 << 30;
    for (int i = 0; i < n; i++) begin
      p = p + (p >> (2 * i));
    end
    return p << 30;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem = v;
    res = 64'd0;
    for (int k = 31; k >= 0; k--) begin
      bitv = 64'd1 << (2 * k);
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

endpackage

[design/cpc_req_if.sv]
interface cpc_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] x_value;
  logic signed [15:0] y_value;
  logic signed [15:0] angle_in;
  logic        [14:0] radius_in;

  modport source (
    output valid, func, x_value, y_value, angle_in, radius_in,
    input  ready
  );
  modport sink (
    input  valid, func, x_value, y_value, angle_in, radius_in,
    output ready
  );
endinterface

[design/cpc_rsp_if.sv]
interface cpc_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] phase_out;
  logic        [15:0] radius_out;
  logic signed [15:0] x_out;
  logic signed [15:0] y_out;

  modport source (
    output valid, phase_out, radius_out, x_out, y_out,
    input  ready
  );
  modport sink (
    input  valid, phase_out, radius_out, x_out, y_out,
    output ready
  );
endinterface

[design/cpc_pre.sv]
module cpc_pre #(
  parameter logic [cpc_pkg::GAIN_W-1:0] INV_GAIN = '0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  cpc_pkg::cpc_req_t   req,
  input  logic                down_en,
  output logic                en,
  output cpc_pkg::cpc_beat_t  beat
);

  localparam int ProdW = 16 + cpc_pkg::GAIN_W + 1;
  localparam int RoundSh = 30 - cpc_pkg::FRAC_BITS;

  // first register: setup and gain multiply
  logic                            a_valid;
  logic                            a_func;
  logic                            a_zero;
  logic signed [cpc_pkg::VEC_W-1:0] a_x;
  logic signed [cpc_pkg::VEC_W-1:0] a_y;
  logic        [31:0]              a_z;
  logic signed [ProdW-1:0]         a_prod;

  logic                            a_en;
  logic                            b_en;
  logic signed [cpc_pkg::VEC_W-1:0] xs;
  logic signed [cpc_pkg::VEC_W-1:0] ys;
  logic                            flip;
  logic signed [15:0]              rad;
  logic signed [cpc_pkg::GAIN_W:0] gain_s;
  logic signed [ProdW-1:0]         prod_next;
  logic signed [ProdW-1:0]         round_sum;
  cpc_pkg::cpc_beat_t              beat_next;

  assign b_en = !beat.valid || down_en;
  assign a_en = !a_valid || b_en;
  // take a new item only when the first register can load it
  assign en   = a_en;

  always_comb begin
    xs = cpc_pkg::VEC_W'(req.x_value) <<< cpc_pkg::FRAC_BITS;
    ys = cpc_pkg::VEC_W'(req.y_value) <<< cpc_pkg::FRAC_BITS;
    flip = (req.angle_in > 16'sd16384) || (req.angle_in < -16'sd16384);
    rad = signed'({1'b0, req.radius_in});
    if (flip) begin
      rad = -rad;
    end
    gain_s = signed'({1'b0, INV_GAIN});
    prod_next = rad * gain_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= req_valid;
      a_func  <= req.func;
      a_zero  <= (req.x_value == 16'sd0) && (req.y_value == 16'sd0);
      a_prod  <= prod_next;
      if (req.func) begin
        a_x <= '0;
        a_y <= '0;
        a_z <= {req.angle_in, 16'h0000} + (flip ? 32'h8000_0000 : 32'h0000_0000);
      end else if (req.x_value < 16'sd0) begin
        // left half-plane: negate and start from pi
        a_x <= -xs;
        a_y <= -ys;
        a_z <= 32'h8000_0000;
      end else begin
        a_x <= xs;
        a_y <= ys;
        a_z <= 32'h0000_0000;
      end
    end
  end

  // second register: round the scaled radius into the start vector
  always_comb begin
    round_sum = a_prod + (ProdW'(1) <<< (RoundSh - 1));
    beat_next.valid = a_valid;
    beat_next.func  = a_func;
    beat_next.zero  = a_zero;
    beat_next.z     = a_z;
    if (a_func) begin
      beat_next.x = cpc_pkg::VEC_W'(round_sum >>> RoundSh);
      beat_next.y = '0;
    end else begin
      beat_next.x = a_x;
      beat_next.y = a_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (b_en) begin
      beat <= beat_next;
    end
  end

endmodule

[design/cpc_stage.sv]
module cpc_stage #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  cpc_pkg::cpc_beat_t  beat_in,
  input  logic                down_en,
  output logic                en,
  output cpc_pkg::cpc_beat_t  beat
);

  logic signed [cpc_pkg::VEC_W-1:0] dx;
  logic signed [cpc_pkg::VEC_W-1:0] dy;
  logic                            ccw;
  cpc_pkg::cpc_beat_t              beat_next;

  assign en = !beat.valid || down_en;

  always_comb begin
    dx = beat_in.y >>> IDX;
    dy = beat_in.x >>> IDX;
    // rotation follows the phase sign, vectoring drives y towards zero
    ccw = beat_in.func ? !beat_in.z[31] : beat_in.y[cpc_pkg::VEC_W-1];
    beat_next = beat_in;
    if (ccw) begin
      beat_next.x = beat_in.x - dx;
      beat_next.y = beat_in.y + dy;
      beat_next.z = beat_in.z - cpc_pkg::ATAN_TAB[IDX];
    end else begin
      beat_next.x = beat_in.x + dx;
      beat_next.y = beat_in.y - dy;
      beat_next.z = beat_in.z + cpc_pkg::ATAN_TAB[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (en) begin
      beat <= beat_next;
    end
  end

endmodule

[design/cpc_post.sv]
module cpc_post #(
  parameter logic [cpc_pkg::GAIN_W-1:0] INV_GAIN = '0
) (
  input  logic                clk,
  input  logic                rst,
  input  cpc_pkg::cpc_beat_t  beat_in,
  input  logic                down_en,
  output logic                en,
  output cpc_pkg::cpc_res_t   res
);

  localparam int ProdW   = cpc_pkg::VEC_W + cpc_pkg::GAIN_W + 1;
  localparam int RadSh   = 30 + cpc_pkg::FRAC_BITS;
  localparam int RadW    = ProdW - RadSh;
  localparam int VecOutW = cpc_pkg::VEC_W - cpc_pkg::FRAC_BITS;

  // multiply register
  cpc_pkg::cpc_beat_t       p_beat;
  logic signed [ProdW-1:0]  p_prod;
  logic                     p_en;

  logic signed [cpc_pkg::GAIN_W:0]  gain_s;
  logic signed [ProdW-1:0]          rad_sum;
  logic signed [RadW-1:0]           rad_r;
  logic signed [cpc_pkg::VEC_W-1:0] xs;
  logic signed [cpc_pkg::VEC_W-1:0] ys;
  logic [31:0]                      ang_sum;
  cpc_pkg::cpc_res_t                res_next;

  function automatic logic signed [15:0] sat16(input logic signed [VecOutW-1:0] v);
    logic signed [15:0] r;
    if (v > VecOutW'(32767)) begin
      r = 16'sd32767;
    end else if (v < -VecOutW'(32767)) begin
      r = -16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign en     = !p_beat.valid || p_en;
  assign p_en   = !res.valid || down_en;
  assign gain_s = signed'({1'b0, INV_GAIN});

  always_ff @(posedge clk) begin
    if (rst) begin
      p_beat.valid <= 1'b0;
    end else if (en) begin
      p_beat <= beat_in;
      p_prod <= beat_in.x * gain_s;
    end
  end

  always_comb begin
    rad_sum = p_prod + (ProdW'(1) <<< (RadSh - 1));
    rad_r   = signed'(rad_sum[ProdW-1:RadSh]);
    xs      = p_beat.x + (cpc_pkg::VEC_W'(1) <<< (cpc_pkg::FRAC_BITS - 1));
    ys      = p_beat.y + (cpc_pkg::VEC_W'(1) <<< (cpc_pkg::FRAC_BITS - 1));
    ang_sum = p_beat.z + 32'h0000_8000;

    res_next.valid      = p_beat.valid;
    res_next.func       = p_beat.func;
    res_next.phase_out  = '0;
    res_next.radius_out = '0;
    res_next.x_out      = '0;
    res_next.y_out      = '0;
    if (p_beat.func) begin
      res_next.x_out = sat16(signed'(xs[cpc_pkg::VEC_W-1:cpc_pkg::FRAC_BITS]));
      res_next.y_out = sat16(signed'(ys[cpc_pkg::VEC_W-1:cpc_pkg::FRAC_BITS]));
    end else if (!p_beat.zero) begin
      res_next.phase_out = signed'(ang_sum[31:16]);
      if (rad_r < 0) begin
        res_next.radius_out = '0;
      end else if (rad_r > RadW'(65535)) begin
        res_next.radius_out = 16'hFFFF;
      end else begin
        res_next.radius_out = rad_r[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (p_en) begin
      res <= res_next;
    end
  end

endmodule

[design/cartesian_polar_converter.sv]
// Channel  Dir  Fields                                          Handshake
// req      in   func, x_value, y_value, angle_in, radius_in     valid / ready
// rsp      out  phase_out, radius_out, x_out, y_out             valid / ready
//
// One item per cycle while rsp.ready keeps the output moving; the path holds two setup registers,
// one register per unrolled micro-rotation, the gain multiply register and the output register.
// Reset clears the valid bit of every stage; payload registers are not reset.
// A stage holds its item while the next one is full, so empty stages close up
// behind a stalled output and no item is lost or repeated.
`include "cartesian_polar_converter_assert.svh"

module cartesian_polar_converter #(
  parameter int ITERATIONS = 16
) (
  input logic       clk,
  input logic       rst,
  cpc_req_if.sink   req,
  cpc_rsp_if.source rsp
);

  localparam int Steps = (ITERATIONS > cpc_pkg::ATAN_LEN) ? cpc_pkg::ATAN_LEN : ITERATIONS;
  localparam logic [63:0] GainSq   = cpc_pkg::gain_sq(Steps);
  localparam logic [63:0] GainRoot = cpc_pkg::isqrt(GainSq);
  localparam logic [63:0] InvGain  = (64'd1 << 60) / GainRoot;
  localparam logic [cpc_pkg::GAIN_W-1:0] InvGainQ = InvGain[cpc_pkg::GAIN_W-1:0];

  cpc_pkg::cpc_req_t  req_item;
  cpc_pkg::cpc_beat_t beat [Steps+1];
  logic [Steps:0]     stage_en;
  cpc_pkg::cpc_res_t  res;

  assign req_item.func      = req.func;
  assign req_item.x_value   = req.x_value;
  assign req_item.y_value   = req.y_value;
  assign req_item.angle_in  = req.angle_in;
  assign req_item.radius_in = req.radius_in;

  cpc_pre #(
    .INV_GAIN (InvGainQ)
  ) u_pre (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req       (req_item),
    .down_en   (stage_en[0]),
    .en        (req.ready),
    .beat      (beat[0])
  );

  for (genvar k = 0; k < Steps; k++) begin : g_rot
    cpc_stage #(
      .IDX (k)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .beat_in (beat[k]),
      .down_en (stage_en[k+1]),
      .en      (stage_en[k]),
      .beat    (beat[k+1])
    );
  end

  cpc_post #(
    .INV_GAIN (InvGainQ)
  ) u_post (
    .clk     (clk),
    .rst     (rst),
    .beat_in (beat[Steps]),
    .down_en (rsp.ready),
    .en      (stage_en[Steps]),
    .res     (res)
  );

  assign rsp.valid      = res.valid;
  assign rsp.phase_out  = res.phase_out;
  assign rsp.radius_out = res.radius_out;
  assign rsp.x_out      = res.x_out;
  assign rsp.y_out      = res.y_out;

  // an empty output register lets every stage advance
  `CPC_ASSERT_IMPLY(a_ready_when_drained, clk, rst, !rsp.valid, req.ready)
  `CPC_ASSERT_IMPLY(a_polar_clears_xy, clk, rst, rsp.valid && !res.func, (rsp.x_out == 16'sd0) && (rsp.y_out == 16'sd0))
  `CPC_ASSERT_IMPLY(a_rect_clears_polar, clk, rst, rsp.valid && res.func, (rsp.phase_out == 16'sd0) && (rsp.radius_out == 16'd0))
  `CPC_ASSERT_NEXT(a_reset_empties, clk, rst, !rsp.valid)

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int ROTATIONS    = 16;
  localparam int ARC_LEN      = 24;
  localparam int STEPS        = (ROTATIONS > ARC_LEN) ? ARC_LEN : ROTATIONS;
  localparam int FRAC         = 12;
  localparam int LATENCY      = ROTATIONS + 4;
  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum bit {
    TO_POLAR     = 1'b0,
    TO_CARTESIAN = 1'b1
  } conv_func_e;

  typedef struct packed {
    logic signed [15:0] angle;
    logic        [15:0] radius;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } conv_res_t;

  typedef struct {
    cpc_pkg::cpc_req_t item;
    bit                zero;
  } case_row_t;

  // atan(2^-i) scaled so that 2^31 is pi
  localparam logic [31:0] ARC [ARC_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpc_req_if req();
  cpc_rsp_if rsp();

  cartesian_polar_converter #(.ITERATIONS(ROTATIONS)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  conv_res_t   pending [$];
  case_row_t   rows [$];
  conv_res_t   front;
  longint      inv_gain;
  int          errors = 0;
  int          cycles = 0;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cartesian_polar_converter verification failed");
      $finish;
    end
  end

  // 1/K of the CORDIC in Q30, from the product of sqrt(1 + 2^-2i)
  function automatic longint gain_inverse();
    longint unsigned p;
    longint unsigned v;
    longint unsigned root;
    longint unsigned b;
    p = 64'd1 << 30;
    for (int i = 0; i < STEPS; i++) p += p >> (2 * i);
    v = p << 30;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return longint'((64'd1 << 60) / root);
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] clip(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32767) return -16'sd32767;
    return v[15:0];
  endfunction

  function automatic conv_res_t convert(cpc_pkg::cpc_req_t it);
    conv_res_t   r;
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    longint      mag;
    longint      rad;
    logic [31:0] z;
    r = '0;
    if (it.func == TO_POLAR) begin
      if (it.x_value == 0 && it.y_value == 0) return r;
      x = longint'(it.x_value) * (longint'(1) << FRAC);
      y = longint'(it.y_value) * (longint'(1) << FRAC);
      z = 32'd0;
      // fold the left half plane onto the right one
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          z += ARC[i];
        end else begin
          x -= dx;
          y += dy;
          z -= ARC[i];
        end
      end
      mag = round_shift(x * inv_gain, 30 + FRAC);
      if (mag < 0) mag = 0;
      if (mag > 65535) mag = 65535;
      z = z + 32'h0000_8000;
      r.angle = z[31:16];
      r.radius = mag[15:0];
    end else begin
      rad = longint'(it.radius_in);
      z = {it.angle_in, 16'h0000};
      if (it.angle_in > 16384 || it.angle_in < -16384) begin
        z += 32'h8000_0000;
        rad = -rad;
      end
      x = round_shift(rad * (longint'(1) << FRAC) * inv_gain, 30);
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (!z[31]) begin
          x -= dx;
          y += dy;
          z -= ARC[i];
        end else begin
          x += dx;
          y -= dy;
          z += ARC[i];
        end
      end
      r.x = clip(round_shift(x, FRAC));
      r.y = clip(round_shift(y, FRAC));
    end
    return r;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h8001;
          2: return 16'hFFFF;
          3: return 16'h0000;
          4: return 16'h0001;
          default: return 16'h7FFF;
        endcase
      end
      1: return 16'(int'($urandom_range(0, 128)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cpc_pkg::cpc_req_t random_item();
    cpc_pkg::cpc_req_t it;
    int                b;
    it.func = 1'($urandom_range(0, 1));
    it.x_value = pick16();
    it.y_value = pick16();
    case ($urandom_range(0, 7))
      0: begin
        // straddle the quadrant boundary where the radius flips
        b = 16384 + int'($urandom_range(0, 4)) - 2;
        it.angle_in = $urandom_range(0, 1) ? 16'(b) : 16'(-b);
      end
      1: it.angle_in = pick16();
      default: it.angle_in = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: it.radius_in = 15'h7FFF;
      1: it.radius_in = 15'($urandom_range(0, 3));
      default: it.radius_in = 15'($urandom);
    endcase
    return it;
  endfunction

  function automatic int draw_wait(bit calm);
    return calm ? 0 : int'($urandom_range(0, 13));
  endfunction

  task automatic add_row(conv_func_e f, int x, int y, int ang, int rad, bit zero = 1'b0);
    case_row_t r;
    r.item.func = f;
    r.item.x_value = 16'(x);
    r.item.y_value = 16'(y);
    r.item.angle_in = 16'(ang);
    r.item.radius_in = 15'(rad);
    r.zero = zero;
    rows.push_back(r);
  endtask

  task automatic send(cpc_pkg::cpc_req_t item, conv_res_t want, int gap);
    if (gap > 0) begin
      @(negedge clk);
      req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid <= 1'b1;
    req.func <= item.func;
    req.x_value <= item.x_value;
    req.y_value <= item.y_value;
    req.angle_in <= item.angle_in;
    req.radius_in <= item.radius_in;
    do @(posedge clk); while (req.ready !== 1'b1);
    pending.push_back(want);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing pending: angle %0d radius %0d x %0d y %0d",
                 $time, rsp.phase_out, rsp.radius_out, rsp.x_out, rsp.y_out);
      end else begin
        front = pending.pop_front();
        check_field("phase_out", front.angle, rsp.phase_out);
        check_field("radius_out", front.radius, rsp.radius_out);
        check_field("x_out", front.x, rsp.x_out);
        check_field("y_out", front.y, rsp.y_out);
      end
    end
  end

  // Result side: stall for a drawn number of cycles before taking each item
  initial begin
    int stall;
    rsp.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = draw_wait(sink_calm);
      if (stall > 0) begin
        @(negedge clk);
        rsp.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
    end
  end

  initial begin
    cpc_pkg::cpc_req_t it;
    req.valid = 1'b0;
    req.func = 1'b0;
    req.x_value = '0;
    req.y_value = '0;
    req.angle_in = '0;
    req.radius_in = '0;
    inv_gain = gain_inverse();

    // zero vector and zero radius give an all-zero result
    add_row(TO_POLAR, 0, 0, 12345, 321, 1'b1);
    add_row(TO_POLAR, 32767, 32767, -32768, 32767);
    add_row(TO_POLAR, -32768, -32768, 0, 0);
    add_row(TO_POLAR, -32768, 32767, 32767, 1);
    add_row(TO_POLAR, 32767, -32768, -1, 16384);
    add_row(TO_POLAR, -32768, 0, 0, 0);
    add_row(TO_POLAR, 32767, 0, 0, 0);
    add_row(TO_POLAR, 0, 32767, 0, 0);
    add_row(TO_POLAR, 0, -32768, 0, 0);
    add_row(TO_POLAR, -1, 0, 0, 0);
    add_row(TO_POLAR, 1, 0, 0, 0);
    add_row(TO_POLAR, -1, -1, 0, 0);
    add_row(TO_POLAR, 1, -1, 0, 0);
    add_row(TO_CARTESIAN, 1234, -77, 12345, 0, 1'b1);
    add_row(TO_CARTESIAN, -32768, 32767, -32768, 0, 1'b1);
    add_row(TO_CARTESIAN, 0, 0, 0, 32767);
    add_row(TO_CARTESIAN, 0, 0, 32767, 32767);
    add_row(TO_CARTESIAN, 32767, -32768, -32768, 32767);
    add_row(TO_CARTESIAN, 0, 0, 16384, 32767);
    add_row(TO_CARTESIAN, 0, 0, 16385, 32767);
    add_row(TO_CARTESIAN, 0, 0, -16384, 32767);
    add_row(TO_CARTESIAN, 0, 0, -16385, 32767);
    add_row(TO_CARTESIAN, -1, -1, 8192, 32767);
    add_row(TO_CARTESIAN, 0, 0, -1, 1);
    add_row(TO_CARTESIAN, 0, 0, 0, 1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[k]) begin
      send(rows[k].item, rows[k].zero ? conv_res_t'('0) : convert(rows[k].item),
           draw_wait(src_calm));
    end
    hold_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // change the idling mix every block of items
      if (n % 150 == 0) begin
        src_calm = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      it = random_item();
      send(it, convert(it), draw_wait(src_calm));
    end

    hold_until_drained();
    repeat (LATENCY + 16) @(posedge clk);
    if (errors == 0) begin
      $display("cartesian_polar_converter verification clean");
    end else begin
      $display("cartesian_polar_converter verification failed");
    end
    $finish;
  end

endmodule
